// ===== hw/rtl/epi_pkg.sv =====
// Shared constants, codes and weight ROM content function for the eased position
// interpolator. No dependencies; used by every other file of the block.

package epi_pkg;

	localparam int STEPS                = 100;
	localparam int PROGRESS_W           = 7;
	localparam int WEIGHT_FRAC_BITS_DEF = 16;
	localparam int CFG_INDEX_W          = 2;
	localparam int CFG_DATA_W           = 16;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned STEPS_L = 64'(STEPS);
	localparam longint unsigned STEPS2  = STEPS_L * STEPS_L;
	localparam longint unsigned STEPS3  = STEPS_L * STEPS_L * STEPS_L;

	// (2n-1)*2n for the Taylor terms n = 1..10
	localparam longint unsigned TAYLOR_DIV [1:10] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182, 64'd240, 64'd306, 64'd380
	};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_X   = 2'd0,
		REG_END_X     = 2'd1,
		REG_EASE_MODE = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_LINEAR = 2'd0,
		MODE_SINE   = 2'd1,
		MODE_QUAD   = 2'd2,
		MODE_CUBIC  = 2'd3
	} ease_mode_t;

	// (1 - cos(pi t)) / 2 for the first half of the run, cos from a Q30 Taylor series
	function automatic longint unsigned sine_half(longint unsigned k, int wfb);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		longint unsigned lo;
		x    = (PI_Q30 * k) / STEPS_L;
		x2   = (x * x) >> 30;
		term = Q30_ONE;
		acc  = longint'(Q30_ONE);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if (n % 2 == 1) acc = acc - longint'(term);
			else            acc = acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > longint'(Q30_ONE)) acc = longint'(Q30_ONE);
		lo = Q30_ONE - longint'(acc);
		return (lo + (64'd1 << (30 - wfb))) >> (31 - wfb);
	endfunction

	function automatic longint unsigned ease_weight(ease_mode_t mode, longint unsigned k,
			int wfb);
		longint unsigned one;
		longint unsigned m;
		one = 64'd1 << wfb;
		m   = STEPS_L - k;
		case (mode)
			MODE_LINEAR: return (k * one + STEPS_L / 2) / STEPS_L;
			MODE_SINE: begin
				if (2 * k <= STEPS_L) return sine_half(k, wfb);
				return one - sine_half(m, wfb);
			end
			MODE_QUAD:   return (k * k * one + STEPS2 / 2) / STEPS2;
			default:     return one - (m * m * m * one + STEPS3 / 2) / STEPS3;
		endcase
	endfunction

endpackage

// ===== hw/rtl/epi_weight_rom.sv =====
// Eased weight ROM: one row per mode, one entry per progress step, registered read.
// Depends on epi_pkg for the step count and the weight function.

module epi_weight_rom #(
	parameter int WEIGHT_FRAC_BITS = epi_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                rd_en,
	input  logic [epi_pkg::PROGRESS_W+1:0]      rd_addr,   // {mode, step}
	output logic [WEIGHT_FRAC_BITS:0]           rd_data
);

	localparam int WW    = WEIGHT_FRAC_BITS + 1;
	localparam int ROW   = 1 << epi_pkg::PROGRESS_W;
	localparam int DEPTH = 4 * ROW;

	typedef logic [WW-1:0] weight_t;
	typedef weight_t rom_array_t [DEPTH];

	function automatic rom_array_t build_rom();
		rom_array_t r;
		for (int m = 0; m < 4; m++) begin
			for (int k = 0; k < ROW; k++) begin
				if (k <= epi_pkg::STEPS)
					r[m * ROW + k] = WW'(epi_pkg::ease_weight(
						epi_pkg::ease_mode_t'(m[1:0]), 64'(k), WEIGHT_FRAC_BITS));
				else
					r[m * ROW + k] = '0;
			end
		end
		return r;
	endfunction

	localparam rom_array_t WEIGHTS = build_rom();

	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= WEIGHTS[rd_addr];
	end

endmodule

// ===== hw/rtl/eased_position_interpolator.sv =====
// Eased position interpolator, top level: progress counter, weight ROM lookup,
// multiply and rounding. Depends on epi_pkg and epi_weight_rom.
//
//  channel  direction  handshake             payload
//  s_*      in         s_tvalid / s_tready   tdata[0] advance
//  m_*      out        m_tvalid / m_tready   tdata position_q8, progress; tlast done_res
//  cfg_*    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item passes the ROM read, the multiply and the round and add, each registered.
// A new item is taken only once the last one has left the ROM read stage.
// The output register holds a result until taken; a stalled output holds the
// multiply stage and then the input. Reset clears progress, registers and valids.

module eased_position_interpolator #(
	parameter int WEIGHT_FRAC_BITS = epi_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,    // [0] advance, [7:1] zero
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,    // [23:0] position_q8, [30:24] progress
	output logic                              m_tlast,    // done_res
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [epi_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [epi_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int KW = epi_pkg::PROGRESS_W;
	localparam int WW = WEIGHT_FRAC_BITS + 1;
	localparam int PW = 17 + WW + 1;
	localparam int SW = PW + 8;
	localparam logic [KW-1:0] K_MAX = KW'(epi_pkg::STEPS);
	localparam logic [SW-1:0] HALF  = SW'(1) << (WEIGHT_FRAC_BITS - 1);

	logic signed [15:0] start_x_q;
	logic signed [15:0] end_x_q;
	logic [1:0]         ease_mode_q;
	logic [KW-1:0]      step_count_q;

	logic               in_acc;
	logic [KW-1:0]      k_next;
	logic               s1_adv;
	logic               s2_adv;

	logic               valid_s1;
	logic signed [16:0] diff_s1;
	logic signed [15:0] start_s1;
	logic [KW-1:0]      progress_s1;
	logic [WW-1:0]      weight_s1;

	logic               valid_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [15:0] start_s2;
	logic [KW-1:0]      progress_s2;

	logic signed [SW-1:0] scaled;
	logic signed [SW-1:0] quot;
	logic [23:0]        pos_next;

	logic               out_valid_q;
	logic [23:0]        position_q;
	logic [KW-1:0]      progress_q;
	logic               done_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !valid_s1;
	assign in_acc    = s_tvalid && s_tready;
	assign s2_adv    = valid_s2 && (!out_valid_q || m_tready);
	assign s1_adv    = valid_s1 && (!valid_s2 || s2_adv);

	// advance saturates at the last step
	always_comb begin
		k_next = step_count_q;
		if (s_tdata[0] && (step_count_q < K_MAX)) k_next = step_count_q + KW'(1);
	end

	epi_weight_rom #(
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
	) u_rom (
		.clk    (clk),
		.rd_en  (in_acc),
		.rd_addr({ease_mode_q, k_next}),
		.rd_data(weight_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q   <= '0;
			end_x_q     <= '0;
			ease_mode_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (epi_pkg::cfg_reg_t'(cfg_index))
				epi_pkg::REG_START_X:   start_x_q   <= $signed(cfg_data);
				epi_pkg::REG_END_X:     end_x_q     <= $signed(cfg_data);
				epi_pkg::REG_EASE_MODE: ease_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_acc) step_count_q <= k_next;

			if (in_acc)      valid_s1 <= 1'b1;
			else if (s1_adv) valid_s1 <= 1'b0;

			if (s1_adv)      valid_s2 <= 1'b1;
			else if (s2_adv) valid_s2 <= 1'b0;

			if (s2_adv)        out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			diff_s1     <= 17'(end_x_q) - 17'(start_x_q);
			start_s1    <= start_x_q;
			progress_s1 <= k_next;
		end
		if (s1_adv) begin
			prod_s2     <= PW'(diff_s1) * PW'($signed({1'b0, weight_s1}));
			start_s2    <= start_s1;
			progress_s2 <= progress_s1;
		end
		if (s2_adv) begin
			position_q <= pos_next;
			progress_q <= progress_s2;
			done_q     <= (progress_s2 == K_MAX);
		end
	end

	// round half up, also for negative products
	always_comb begin
		scaled   = $signed({prod_s2, 8'd0}) + $signed(HALF);
		quot     = scaled >>> WEIGHT_FRAC_BITS;
		pos_next = {start_s2, 8'd0} + quot[23:0];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, progress_q, position_q};
	assign m_tlast  = done_q;

endmodule

// ===== hw/rtl/epi_checker.sv =====
// Port-level checks for the eased position interpolator, bound to the top level.
// Depends on epi_pkg for the step count.

module epi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	localparam logic [6:0] K_MAX = 7'(epi_pkg::STEPS);

	// one item in the front stage at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in successive cycles");

	a_progress_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[30:24] <= K_MAX))
		else $error("progress beyond last step");

	a_done_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[30:24] == K_MAX)))
		else $error("done flag disagrees with progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind eased_position_interpolator epi_checker u_epi_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

// ===== dv/eased_position_interpolator_test.sv =====
// Self-checking testbench for eased_position_interpolator: a directed table, then
// random register settings and ticks, checked against given or modelled positions.
// Depends on epi_pkg and the block's RTL only.
`timescale 1ns / 1ps

module eased_position_interpolator_test;

	localparam int          WFB        = 16;
	localparam int          LAT        = 8;
	localparam int          CYCLE_CAP  = 400000;
	localparam int          TICK_COUNT = 1100;
	localparam logic [1:0]  REG_NONE   = 2'd3;
	localparam longint unsigned PI_FIXED = 64'd3373259426;
	localparam longint unsigned UNIT30   = 64'd1 << 30;

	typedef struct packed {
		logic [23:0] position;
		logic [6:0]  progress;
		logic        done;
	} position_t;

	typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  index;
		logic [15:0] data;
		logic [7:0]  tick_byte;
		logic        typed;
		position_t   want;
	} stim_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [epi_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [epi_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	// position model state
	logic signed [15:0]  start_px;
	logic signed [15:0]  end_px;
	epi_pkg::ease_mode_t curve;
	int                  step_k;

	position_t pending_positions[$];
	int        mismatches = 0;
	int        ticks_sent = 0;
	int        cycle_no   = 0;
	bit        calm       = 1'b0;

	eased_position_interpolator #(.WEIGHT_FRAC_BITS(WFB)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no == CYCLE_CAP) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99) >= 29);

	// (1 - cos(pi k/S)) / 2 for the first half, cos by Taylor series in Q30
	function automatic longint unsigned half_cos_weight(longint unsigned k);
		longint unsigned ang;
		longint unsigned ang_sq;
		longint unsigned term;
		longint          cosv;
		ang    = (PI_FIXED * k) / longint'(epi_pkg::STEPS);
		ang_sq = (ang * ang) >> 30;
		term   = UNIT30;
		cosv   = longint'(UNIT30);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * ang_sq) >> 30) / longint'((2 * n - 1) * (2 * n));
			cosv = (n % 2 == 1) ? cosv - longint'(term) : cosv + longint'(term);
		end
		if (cosv < 0) cosv = 0;
		if (cosv > longint'(UNIT30)) cosv = longint'(UNIT30);
		return ((UNIT30 - longint'(cosv)) + (64'd1 << (30 - WFB))) >> (31 - WFB);
	endfunction

	function automatic longint unsigned eased_weight(epi_pkg::ease_mode_t mode, int k);
		longint unsigned one;
		longint unsigned s;
		longint unsigned kk;
		longint unsigned rest;
		one  = 64'd1 << WFB;
		s    = longint'(epi_pkg::STEPS);
		kk   = longint'(k);
		rest = s - kk;
		case (mode)
			epi_pkg::MODE_LINEAR: return (kk * one + s / 2) / s;
			epi_pkg::MODE_SINE:
				return (2 * kk <= s) ? half_cos_weight(kk)
					: one - half_cos_weight(rest);
			epi_pkg::MODE_QUAD:   return (kk * kk * one + s * s / 2) / (s * s);
			default:
				return one - (rest * rest * rest * one + s * s * s / 2) / (s * s * s);
		endcase
	endfunction

	// advance progress for one tick and work out the position it reports
	function automatic position_t next_position(logic adv);
		position_t       res;
		longint unsigned w;
		longint          span;
		longint          pos;
		if (adv && step_k < epi_pkg::STEPS) step_k++;
		w    = eased_weight(curve, step_k);
		span = longint'(end_px) - longint'(start_px);
		pos  = longint'(start_px) * 256
			+ ((span * 256 * longint'(w) + (longint'(1) <<< (WFB - 1))) >>> WFB);
		res.position = 24'(pos);
		res.progress = 7'(step_k);
		res.done     = (step_k == epi_pkg::STEPS);
		return res;
	endfunction

	function automatic bit sender_idle();
		return !calm && ($urandom_range(99) < 29);
	endfunction

	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(5))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic stim_row_t write_row(logic [1:0] index, logic [15:0] data);
		stim_row_t r;
		r = '{ROW_WRITE, index, data, 8'h00, 1'b0, '0};
		return r;
	endfunction

	function automatic stim_row_t tick_row(logic [7:0] tick_byte, logic typed,
			position_t want);
		stim_row_t r;
		r = '{ROW_TICK, epi_pkg::REG_START_X, 16'h0000, tick_byte, typed, want};
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_positions.size() == 0) begin
				$error("unexpected result item: %h last %b", m_tdata, m_tlast);
				mismatches++;
			end else begin
				position_t exp_pos;
				exp_pos = pending_positions.pop_front();
				if (m_tdata[23:0] !== exp_pos.position) begin
					$error("position_q8: expected %h, got %h", exp_pos.position, m_tdata[23:0]);
					mismatches++;
				end
				if (m_tdata[30:24] !== exp_pos.progress) begin
					$error("progress: expected %0d, got %0d", exp_pos.progress, m_tdata[30:24]);
					mismatches++;
				end
				if (m_tlast !== exp_pos.done) begin
					$error("done_res: expected %b, got %b", exp_pos.done, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// drain the pipeline first so the new value never meets an item in flight
	task automatic write_reg(logic [1:0] index, logic [15:0] value);
		s_tvalid <= 1'b0;
		while (pending_positions.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			epi_pkg::REG_START_X:   start_px = value;
			epi_pkg::REG_END_X:     end_px   = value;
			epi_pkg::REG_EASE_MODE: curve    = epi_pkg::ease_mode_t'(value[1:0]);
			default: ;
		endcase
	endtask

	task automatic send_tick(logic [7:0] tick_byte, logic typed, position_t want);
		position_t got;
		cfg_valid <= 1'b0;
		while (sender_idle()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= tick_byte;
		do @(posedge clk); while (!s_tready);
		got = next_position(tick_byte[0]);
		pending_positions.push_back(typed ? want : got);
		ticks_sent++;
	endtask

	initial begin
		stim_row_t plan[$];
		logic      adv;

		start_px = '0;
		end_px   = '0;
		curve    = epi_pkg::MODE_LINEAR;
		step_k   = 0;

		plan.push_back(tick_row(8'h00, 1'b1, '{24'h000000, 7'd0, 1'b0}));
		plan.push_back(tick_row(8'h01, 1'b1, '{24'h000000, 7'd1, 1'b0}));
		plan.push_back(write_row(epi_pkg::REG_START_X, 16'h8000));
		plan.push_back(write_row(epi_pkg::REG_END_X, 16'h7FFF));
		plan.push_back(tick_row(8'h00, 1'b0, '0));
		plan.push_back(write_row(epi_pkg::REG_EASE_MODE, 16'(epi_pkg::MODE_SINE)));
		plan.push_back(tick_row(8'h01, 1'b0, '0));
		plan.push_back(write_row(epi_pkg::REG_EASE_MODE, 16'(epi_pkg::MODE_QUAD)));
		plan.push_back(tick_row(8'h00, 1'b0, '0));
		plan.push_back(write_row(epi_pkg::REG_EASE_MODE, 16'(epi_pkg::MODE_CUBIC)));
		plan.push_back(tick_row(8'h01, 1'b0, '0));
		// a write past the last register must change nothing
		plan.push_back(write_row(REG_NONE, 16'hFFFF));
		plan.push_back(tick_row(8'h00, 1'b0, '0));
		plan.push_back(write_row(epi_pkg::REG_START_X, 16'h7FFF));
		plan.push_back(write_row(epi_pkg::REG_END_X, 16'h7FFF));
		// only bit 0 of the tick byte counts
		plan.push_back(tick_row(8'hFE, 1'b1, '{24'h7FFF00, 7'd3, 1'b0}));
		plan.push_back(tick_row(8'hFF, 1'b1, '{24'h7FFF00, 7'd4, 1'b0}));
		plan.push_back(write_row(epi_pkg::REG_START_X, 16'h8000));
		plan.push_back(write_row(epi_pkg::REG_END_X, 16'h8000));
		plan.push_back(tick_row(8'h00, 1'b1, '{24'h800000, 7'd4, 1'b0}));
		plan.push_back(write_row(epi_pkg::REG_END_X, 16'h7FFF));
		plan.push_back(write_row(epi_pkg::REG_EASE_MODE, 16'(epi_pkg::MODE_LINEAR)));
		plan.push_back(tick_row(8'h01, 1'b0, '0));
		plan.push_back(write_row(epi_pkg::REG_START_X, 16'h7FFF));
		plan.push_back(write_row(epi_pkg::REG_END_X, 16'h8000));
		plan.push_back(write_row(epi_pkg::REG_EASE_MODE, 16'(epi_pkg::MODE_SINE)));
		plan.push_back(tick_row(8'h01, 1'b0, '0));
		plan.push_back(tick_row(8'h00, 1'b0, '0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) write_reg(plan[i].index, plan[i].data);
			else send_tick(plan[i].tick_byte, plan[i].typed, plan[i].want);
		end

		// progress cannot rewind without reset, so advance sparsely and sweep
		// settings along the way; saturation is reached well before the end
		while (ticks_sent < TICK_COUNT) begin
			if ($urandom_range(3) != 0) write_reg(epi_pkg::REG_START_X, pick_pixel());
			if ($urandom_range(3) != 0) write_reg(epi_pkg::REG_END_X, pick_pixel());
			if ($urandom_range(3) != 0)
				write_reg(epi_pkg::REG_EASE_MODE, 16'($urandom_range(3)));
			if ($urandom_range(9) == 0) write_reg(REG_NONE, 16'($urandom));
			calm = (ticks_sent >= 500) && (ticks_sent < 650);
			repeat ($urandom_range(12, 4)) begin
				adv = ($urandom_range(7) == 0);
				send_tick({7'd0, adv}, 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;

		while (pending_positions.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
		if (mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
